@@ src/utf8_stream_decoder_macros.svh @@
// Assertion macros of the UTF-8 stream decoder port checker.
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define UTF8SD_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition holds on every word handshake of the output side.
`define UTF8SD_ASSERT_OUT(name, cond, msg) \
    `UTF8SD_ASSERT(name, (m_axis_tvalid && m_axis_tready) |-> (cond), msg)

`endif

@@ src/utf8sd_pkg.sv @@
// Shared types and constants of the UTF-8 stream decoder.
package utf8sd_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;
    localparam int CNT_W  = 2;

    // Result status codes
    typedef enum logic [1:0] {
        ST_VALID   = 2'd0,
        ST_STRAY   = 2'd1,
        ST_BROKEN  = 2'd2,
        ST_BADLEAD = 2'd3
    } status_t;

    localparam logic [CP_W-1:0] REPLACEMENT = 21'h00FFFD;

    // Byte class masks and match values
    localparam logic [BYTE_W-1:0] MASK_ASCII = 8'h80;
    localparam logic [BYTE_W-1:0] MASK_CONT  = 8'hC0;
    localparam logic [BYTE_W-1:0] VAL_CONT   = 8'h80;
    localparam logic [BYTE_W-1:0] MASK_LEAD2 = 8'hE0;
    localparam logic [BYTE_W-1:0] VAL_LEAD2  = 8'hC0;
    localparam logic [BYTE_W-1:0] MASK_LEAD3 = 8'hF0;
    localparam logic [BYTE_W-1:0] VAL_LEAD3  = 8'hE0;
    localparam logic [BYTE_W-1:0] MASK_LEAD4 = 8'hF8;
    localparam logic [BYTE_W-1:0] VAL_LEAD4  = 8'hF0;

    // Payload masks
    localparam logic [BYTE_W-1:0] PAY_LEAD2 = 8'h1F;
    localparam logic [BYTE_W-1:0] PAY_LEAD3 = 8'h0F;
    localparam logic [BYTE_W-1:0] PAY_LEAD4 = 8'h07;
    localparam logic [BYTE_W-1:0] PAY_CONT  = 8'h3F;

    // Bytes dropped after an invalid lead byte
    localparam logic [CNT_W-1:0] SKIP_BADLEAD = 2'd3;

    typedef struct packed {
        logic [CP_W-1:0] cp;
        status_t         status;
        logic            last;
    } result_t;

    // Results produced by one byte, first result in res0
    typedef struct packed {
        result_t    res0;
        result_t    res1;
        logic [1:0] count;
    } step_t;

endpackage

@@ src/utf8sd_decode.sv @@
// Per-byte UTF-8 decode step with the sequence state registers.
module utf8sd_decode
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step_en,
    input  logic [utf8sd_pkg::BYTE_W-1:0] byte_in,
    output utf8sd_pkg::step_t             step
);
    import utf8sd_pkg::*;

    logic [CP_W-1:0]  acc_reg, acc_next;
    logic [CNT_W-1:0] pend_reg, pend_next;
    logic [CNT_W-1:0] skip_reg, skip_next;

    logic             is_cont;
    logic             broken;
    logic             fresh_hit;
    result_t          fresh_res;
    logic [CP_W-1:0]  fresh_acc;
    logic [CNT_W-1:0] fresh_pend;
    logic [CNT_W-1:0] fresh_skip;
    logic [CP_W-1:0]  shifted_acc;

    assign is_cont     = (byte_in & MASK_CONT) == VAL_CONT;
    assign broken      = (pend_reg != '0) && !is_cont;
    assign shifted_acc = {acc_reg[CP_W-7:0], byte_in[5:0] & PAY_CONT[5:0]};

    // Decode the byte as if no sequence were open
    always_comb
    begin
        fresh_hit        = 1'b0;
        fresh_res.cp     = {{(CP_W-BYTE_W){1'b0}}, byte_in};
        fresh_res.status = ST_VALID;
        fresh_res.last   = 1'b1;
        fresh_acc        = broken ? '0 : acc_reg;
        fresh_pend       = '0;
        fresh_skip       = '0;
        priority if ((byte_in & MASK_ASCII) == '0)
        begin
            fresh_hit = 1'b1;
        end
        else if (is_cont)
        begin
            fresh_hit        = 1'b1;
            fresh_res.cp     = REPLACEMENT;
            fresh_res.status = ST_STRAY;
        end
        else if ((byte_in & MASK_LEAD2) == VAL_LEAD2)
        begin
            fresh_acc  = {{(CP_W-BYTE_W){1'b0}}, byte_in & PAY_LEAD2};
            fresh_pend = 2'd1;
        end
        else if ((byte_in & MASK_LEAD3) == VAL_LEAD3)
        begin
            fresh_acc  = {{(CP_W-BYTE_W){1'b0}}, byte_in & PAY_LEAD3};
            fresh_pend = 2'd2;
        end
        else if ((byte_in & MASK_LEAD4) == VAL_LEAD4)
        begin
            fresh_acc  = {{(CP_W-BYTE_W){1'b0}}, byte_in & PAY_LEAD4};
            fresh_pend = 2'd3;
        end
        else
        begin
            fresh_hit        = 1'b1;
            fresh_res.cp     = REPLACEMENT;
            fresh_res.status = ST_BADLEAD;
            fresh_skip       = SKIP_BADLEAD;
        end
    end

    // Choose between drop, continuation and fresh decode
    always_comb
    begin
        acc_next  = acc_reg;
        pend_next = pend_reg;
        skip_next = skip_reg;
        step      = '0;
        if (skip_reg != '0)
        begin
            skip_next = skip_reg - 2'd1;
        end
        else if ((pend_reg != '0) && is_cont)
        begin
            acc_next  = shifted_acc;
            pend_next = pend_reg - 2'd1;
            if (pend_reg == 2'd1)
            begin
                step.res0.cp     = shifted_acc;
                step.res0.status = ST_VALID;
                step.res0.last   = 1'b1;
                step.count       = 2'd1;
            end
        end
        else
        begin
            acc_next  = fresh_acc;
            pend_next = fresh_pend;
            skip_next = fresh_skip;
            if (broken)
            begin
                step.res0.cp     = REPLACEMENT;
                step.res0.status = ST_BROKEN;
                step.res0.last   = !fresh_hit;
                step.res1        = fresh_res;
                step.count       = fresh_hit ? 2'd2 : 2'd1;
            end
            else if (fresh_hit)
            begin
                step.res0  = fresh_res;
                step.count = 2'd1;
            end
        end
    end

    // Advance the sequence state on each decoded byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            pend_reg <= '0;
            skip_reg <= '0;
        end
        else if (step_en)
        begin
            acc_reg  <= acc_next;
            pend_reg <= pend_next;
            skip_reg <= skip_next;
        end
    end

endmodule

@@ src/utf8sd_outq.sv @@
// Four-entry result queue: takes up to two results a cycle, gives one.
module utf8sd_outq
(
    input  logic                clk,
    input  logic                rst_n,
    input  utf8sd_pkg::step_t   push,
    input  logic                pop,
    output logic                room2,
    output logic                head_valid,
    output utf8sd_pkg::result_t head
);
    import utf8sd_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = 2;

    result_t          mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic [PTR_W-1:0] wr_plus1;

    assign wr_plus1   = wr_reg + 2'd1;
    assign room2      = count_reg <= 3'd2;
    assign head_valid = count_reg != '0;
    assign head       = mem_reg[rd_reg];

    // Update pointers and fill level
    always_comb
    begin
        wr_next    = wr_reg + push.count;
        rd_next    = rd_reg + {1'b0, pop};
        count_next = count_reg + {1'b0, push.count} - {2'b00, pop};
    end

    // Write the results of one byte
    always_ff @(posedge clk)
    begin
        if (push.count != '0)
        begin
            mem_reg[wr_reg] <= push.res0;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_plus1] <= push.res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

endmodule

@@ src/utf8_stream_decoder.sv @@
// Top level of the UTF-8 stream decoder: input register, decode step, result queue.
//
//   channel   direction  tdata                  tuser         tlast
//   s_axis    in         [7:0] byte_in          -             -
//   m_axis    out        [20:0] code_point      [1:0] status  last_of_run
//
// One byte a cycle sustained while the queue has two free entries; a byte enters
// the input register, is decoded from it and its results are offered from the queue.
// A byte that gives two results needs two words on the single output port;
// the four-entry queue absorbs that; input stalls while fewer than two entries are free.
// Reset clears the input valid flag, decode state and queue pointers; no clearing pass.
// Input ready depends only on registered state, not on m_axis_tready.
module utf8_stream_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [20:0] code_point, [23:21] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] status
    output logic        m_axis_tlast
);
    import utf8sd_pkg::*;

    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_valid_reg, in_valid_next;
    logic              consume;
    logic              room2;
    logic              head_valid;
    result_t           head;
    step_t             step;
    step_t             push;

    assign consume       = in_valid_reg && room2;
    assign s_axis_tready = !in_valid_reg || consume;

    // Hold the incoming word until the decoder takes it
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_next = 1'b1;
        end
        else if (consume)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    utf8sd_decode u_decode
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (consume),
        .byte_in (in_byte_reg),
        .step    (step)
    );

    // Drop the results of a step that is not taken
    always_comb
    begin
        push = step;
        if (!consume)
        begin
            push.count = '0;
        end
    end

    utf8sd_outq u_outq
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (m_axis_tvalid && m_axis_tready),
        .room2      (room2),
        .head_valid (head_valid),
        .head       (head)
    );

    assign m_axis_tvalid = head_valid;
    assign m_axis_tdata  = {3'b000, head.cp};
    assign m_axis_tuser  = head.status;
    assign m_axis_tlast  = head.last;

endmodule

@@ src/utf8sd_checker.sv @@
// Port-level checker of the UTF-8 stream decoder and its bind.
`include "utf8_stream_decoder_macros.svh"

module utf8sd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);
    import utf8sd_pkg::*;

    logic [CP_W-1:0] out_cp;

    assign out_cp = m_axis_tdata[CP_W-1:0];

    // A stalled output word stays offered
    `UTF8SD_ASSERT(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid, "word dropped")

    // An empty output side always takes a byte
    `UTF8SD_ASSERT(a_in_ready, !m_axis_tvalid |-> s_axis_tready, "byte refused while empty")

    // Every error word carries the replacement character
    `UTF8SD_ASSERT_OUT(a_err_repl, m_axis_tuser == ST_VALID || out_cp == REPLACEMENT, "no U+FFFD")

    // Only a broken-sequence word may precede a second result of the same byte
    `UTF8SD_ASSERT_OUT(a_last_kind, m_axis_tuser == ST_BROKEN || m_axis_tlast, "early word")

    // Code points never exceed 21 bits
    `UTF8SD_ASSERT_OUT(a_cp_range, m_axis_tdata[23:21] == 3'b000, "padding not zero")

endmodule

bind utf8_stream_decoder utf8sd_checker u_checker (.*);

@@ sim/utf8_cp_checker.sv @@
// Code point checker: predicts decoder results from accepted bytes and compares output words.
`timescale 1ns / 1ps

module utf8_cp_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,
    input  logic [1:0]  m_axis_tuser,
    input  logic        m_axis_tlast,
    output int          mismatches,
    output int          outstanding,
    output int          checked
);
    import utf8sd_pkg::*;

    // Decoder state as seen by the predictor
    logic [CP_W-1:0]  cp_acc;
    logic [CNT_W-1:0] cont_left;
    logic [CNT_W-1:0] drop_left;

    result_t expected_cps[$];
    int      err_cnt;
    int      ok_cnt;

    initial
    begin
        cp_acc      = '0;
        cont_left   = '0;
        drop_left   = '0;
        err_cnt     = 0;
        ok_cnt      = 0;
        mismatches  = 0;
        outstanding = 0;
        checked     = 0;
    end

    function automatic result_t make_result(logic [CP_W-1:0] cp, status_t st, logic last);
        result_t r;
        r.cp     = cp;
        r.status = st;
        r.last   = last;
        return r;
    endfunction

    // Advance the predicted state by one byte and queue the code points it yields
    task automatic decode_byte(input logic [7:0] b);
        logic            broke;
        logic            emits;
        logic [CP_W-1:0] cp;
        status_t         st;
        broke = 1'b0;
        emits = 1'b1;
        cp    = REPLACEMENT;
        st    = ST_VALID;
        if (drop_left != 0)
        begin
            drop_left = drop_left - 1'b1;
        end
        else if (cont_left != 0 && (b & MASK_CONT) == VAL_CONT)
        begin
            // extend the open sequence, emit on its last continuation byte
            cp_acc    = {cp_acc[CP_W-7:0], b[5:0]};
            cont_left = cont_left - 1'b1;
            if (cont_left == 0)
                expected_cps.push_back(make_result(cp_acc, ST_VALID, 1'b1));
        end
        else
        begin
            // close a broken sequence, then decode the byte afresh
            if (cont_left != 0)
            begin
                broke     = 1'b1;
                cont_left = '0;
                cp_acc    = '0;
            end
            if ((b & MASK_ASCII) == 0)
            begin
                cp = {{(CP_W-BYTE_W){1'b0}}, b};
            end
            else if ((b & MASK_CONT) == VAL_CONT)
            begin
                st = ST_STRAY;
            end
            else if ((b & MASK_LEAD2) == VAL_LEAD2)
            begin
                cp_acc    = {{(CP_W-BYTE_W){1'b0}}, b & PAY_LEAD2};
                cont_left = 2'd1;
                emits     = 1'b0;
            end
            else if ((b & MASK_LEAD3) == VAL_LEAD3)
            begin
                cp_acc    = {{(CP_W-BYTE_W){1'b0}}, b & PAY_LEAD3};
                cont_left = 2'd2;
                emits     = 1'b0;
            end
            else if ((b & MASK_LEAD4) == VAL_LEAD4)
            begin
                cp_acc    = {{(CP_W-BYTE_W){1'b0}}, b & PAY_LEAD4};
                cont_left = 2'd3;
                emits     = 1'b0;
            end
            else
            begin
                st        = ST_BADLEAD;
                drop_left = SKIP_BADLEAD;
            end
            if (broke)
                expected_cps.push_back(make_result(REPLACEMENT, ST_BROKEN, !emits));
            if (emits)
                expected_cps.push_back(make_result(cp, st, 1'b1));
        end
    endtask

    // Watch both channels; input side first so a word never overtakes its byte
    always @(posedge clk)
    begin
        result_t exp_w;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                decode_byte(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_cps.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t: expected no word, got cp=%h status=%0d last=%0b",
                             $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                end
                else
                begin
                    exp_w = expected_cps.pop_front();
                    ok_cnt++;
                    if (m_axis_tdata !== {3'b000, exp_w.cp} || m_axis_tuser !== exp_w.status
                        || m_axis_tlast !== exp_w.last)
                    begin
                        err_cnt++;
                        $display("%0t: expected %h/%0d/%0b, got %h/%0d/%0b (cp/status/last)",
                                 $time, {3'b000, exp_w.cp}, exp_w.status, exp_w.last,
                                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    end
                end
            end
            mismatches  <= err_cnt;
            outstanding <= expected_cps.size();
            checked     <= ok_cnt;
        end
    end

endmodule

@@ sim/tb_utf8_stream_decoder.sv @@
// Testbench top for the UTF-8 stream decoder: byte stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_utf8_stream_decoder;

    localparam int STALL_LIMIT  = 1000;
    localparam int PHASE_BYTES  = 500;
    localparam int DRAIN_CYCLES = 20;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    int mismatches;
    int outstanding;
    int checked;
    int bytes_sent = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;

    // Opening run: ASCII limits, each sequence length, stray, broken and bad-lead cases
    logic [7:0] directed_bytes [24] = '{
        8'h00, 8'h7F,
        8'hC2, 8'hA9,
        8'hE2, 8'h82, 8'hAC,
        8'hF7, 8'hBF, 8'hBF, 8'hBF,
        8'h80, 8'hBF,
        8'hC3, 8'h41,
        8'hE2, 8'h82, 8'hC3, 8'hA9,
        8'hF0, 8'hFF, 8'hC0, 8'h41, 8'hF8
    };

    utf8_stream_decoder i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    utf8_cp_checker i_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .checked       (checked)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Stall the result side at the current phase rate
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // End the run when no word moves on either side for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles, %0d results still due",
                         $time, STALL_LIMIT, outstanding);
                $display("DONE: errors detected");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Offer one byte after a random gap and hold it until accepted
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Drop valid and hold off until every expected code point has come out
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Emit one character: mostly well formed, some truncated, stray, bad lead or noise
    task automatic send_char();
        int kind;
        int seq_len;
        int conts;
        kind = $urandom_range(99);
        if (kind < 65)
        begin
            seq_len = $urandom_range(1, 4);
            conts   = (kind < 50) ? seq_len - 1 : $urandom_range(0, seq_len - 1);
            case (seq_len)
                1:       send_byte({1'b0, 7'($urandom)});
                2:       send_byte({3'b110, 5'($urandom)});
                3:       send_byte({4'b1110, 4'($urandom)});
                default: send_byte({5'b11110, 3'($urandom)});
            endcase
            repeat (conts)
                send_byte({2'b10, 6'($urandom)});
        end
        else if (kind < 75)
        begin
            send_byte({2'b10, 6'($urandom)});
        end
        else if (kind < 85)
        begin
            send_byte(8'hF8 + 8'($urandom_range(0, 7)));
            repeat (3)
                send_byte(8'($urandom));
        end
        else
        begin
            send_byte(8'($urandom));
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed opening, no idling
        foreach (directed_bytes[i])
            send_byte(directed_bytes[i]);
        drain_results();

        // random phases: none, sender idle, receiver stall, both
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 54; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 54; end
                default: begin send_idle_pct = 38; recv_stall_pct = 38; end
            endcase
            while (bytes_sent < 24 + (phase + 1) * PHASE_BYTES)
                send_char();
            drain_results();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Summary: %0d bytes decoded into %0d checked code points", bytes_sent, checked);
        $display("Covered ASCII, 2-4 byte sequences, stray, broken and bad-lead bytes under four flow mixes");
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
